// ----- hdl/f2cf_pkg.sv -----
// ----------------------------------------------------------------------------
// Float to custom float converter package
// Shared widths, status codes and register reset value.
// ----------------------------------------------------------------------------
package f2cf_pkg;
    localparam int unsigned OUT_BITS_DEF = 32;
    localparam int unsigned EXP_CFG_W    = 5;
    localparam logic [EXP_CFG_W-1:0] EXP_BITS_RST = 5'd8;
    localparam int unsigned STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
endpackage

// ----- hdl/f2cf_core.sv -----
// ----------------------------------------------------------------------------
// Conversion datapath
// Combinational re-encode of one binary32 word into the target format.
// ----------------------------------------------------------------------------
module f2cf_core #(
    parameter int unsigned OUT_BITS = f2cf_pkg::OUT_BITS_DEF
) (
    input  logic [31:0]                      value,
    input  logic [f2cf_pkg::EXP_CFG_W-1:0]   exp_bits,
    output logic [31:0]                      result,
    output logic [f2cf_pkg::STATUS_W-1:0]    status
);
    import f2cf_pkg::*;

    localparam int unsigned HI_LIM = (OUT_BITS - 2 < 30) ? OUT_BITS - 2 : 30;
    localparam int unsigned RW     = OUT_BITS + 24;

    logic [4:0]          ew;
    logic signed [31:0]  e;
    logic signed [31:0]  bias;
    logic signed [31:0]  mw;
    logic signed [31:0]  sh;
    logic [23:0]         sig;
    logic [4:0]          lz;
    logic [7:0]          ef;
    logic [22:0]         mant;
    logic [RW-1:0]       mfull;
    logic [OUT_BITS-1:0] res;

    always_comb begin
        // Clamp the exponent width
        ew = exp_bits;
        if (32'(ew) > HI_LIM) ew = 5'(HI_LIM);
        if (ew == 5'd0) ew = 5'd1;
        // Bias reaches 2^29-1 at the widest exponent field
        bias = signed'((32'd1 << (ew - 5'd1)) - 32'd1);
        mw   = signed'(OUT_BITS - 1) - signed'({27'd0, ew});

        ef   = value[30:23];
        mant = value[22:0];
        // Normalize subnormal inputs: count leading zeros of the fraction
        lz = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (mant[i]) lz = 5'(22 - i);
        end
        if (ef == 8'd0) begin
            sig = {1'b0, mant} << (lz + 5'd1);
            e   = -32'sd127 - signed'({27'd0, lz});
        end else begin
            sig = {1'b1, mant};
            e   = signed'({24'd0, ef}) - 32'sd127;
        end

        res    = '0;
        status = ST_OK;
        mfull  = '0;
        sh     = '0;
        if (ef == 8'hFF) begin
            status = ST_OVERFLOW;
        end else if (ef == 8'd0 && mant == 23'd0) begin
            res = '0;
        end else if (e > bias || (e == bias && sig[22:0] != 23'd0)) begin
            status = ST_OVERFLOW;
        end else if (e < 32'sd1 - bias - mw) begin
            status = ST_UNDERFLOW;
        end else if (e >= 32'sd1 - bias) begin
            // Normal target: place fraction at top of significand
            mfull = RW'({sig[22:0], 1'b0}) << mw;
            res   = OUT_BITS'(mfull[RW-1:24]);
            res   = res | (OUT_BITS'(e + bias) << mw);
            res[OUT_BITS-1] = value[31];
        end else begin
            // Subnormal target
            sh    = e + bias + mw;
            mfull = RW'(sig) << sh;
            res   = OUT_BITS'(mfull[RW-1:24]);
            res[OUT_BITS-1] = value[31];
        end
        result = 32'(res);
    end
endmodule

// ----- hdl/float_to_custom_float_convert.sv -----
// ----------------------------------------------------------------------------
// Float to custom float converter
// Re-encodes binary32 words into a float with a configurable exponent width.
// ----------------------------------------------------------------------------
// Output: the result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the conversion is a single combinational
// pass into the result register, which stalls only under m_tready low.
// Reset: aresetn low empties the result register and sets exp_bits to 8.
module float_to_custom_float_convert #(
    parameter int unsigned OUT_BITS = f2cf_pkg::OUT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [f2cf_pkg::EXP_CFG_W-1:0] cfg_data,   // exp_bits
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,                        // value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata                         // result[31:0], status[33:32]
);
    import f2cf_pkg::*;

    logic [EXP_CFG_W-1:0] exp_bits_reg;
    logic                 valid_reg;
    logic [31:0]          result_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [31:0]          result_next;
    logic [STATUS_W-1:0]  status_next;

    f2cf_core #(.OUT_BITS(OUT_BITS)) u_core (
        .value    (s_tdata),
        .exp_bits (exp_bits_reg),
        .result   (result_next),
        .status   (status_next)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {6'd0, status_reg, result_reg};

    // Hold config, advance the result register on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_bits_reg <= EXP_BITS_RST;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) exp_bits_reg <= cfg_data;
            if (s_tready) valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_tready |=> valid_reg && $stable(result_reg))
        else $error("result lost under stall");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && status_reg != ST_OK |-> result_reg == 32'd0)
        else $error("error result not zero");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> status_reg != 2'd3)
        else $error("bad status code");
endmodule
